// ----- hdl/adamwu_pkg.sv -----
package adamwu_pkg;

  localparam int RowsMaxDef = 64;
  localparam int ColsMaxDef = 64;

  localparam int LrW   = 24;
  localparam int BetaW = 16;
  localparam int EpsW  = 16;
  localparam int DataW = 32;
  localparam int IdxW  = 6;
  localparam int MomW  = 32;
  localparam int VarW  = 48;
  localparam int PowW  = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  localparam int MulW = 34;
  localparam int ProdW = 2 * MulW;
  localparam int AccW = 90;

  localparam int DivN    = 88;
  localparam int DivDsrW = 32;
  localparam int DivCntW = 7;

  localparam int SqrtInW  = 64;
  localparam int SqrtOutW = 32;
  localparam int SqrtCntW = 6;

  localparam logic [PowW-1:0]  OneQ31     = 32'h8000_0000;
  localparam logic [LrW-1:0]   LrReset    = 24'd16777;
  localparam logic [BetaW-1:0] Beta1Reset = 16'd58982;
  localparam logic [BetaW-1:0] Beta2Reset = 16'd65470;
  localparam logic [EpsW-1:0]  EpsReset   = 16'd43;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LR    = 2'd0,
    CFG_BETA1 = 2'd1,
    CFG_BETA2 = 2'd2,
    CFG_EPS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_P1, ST_P2, ST_GR, ST_MO, ST_G, ST_MG, ST_GS,
    ST_VLO, ST_VHI, ST_GLO, ST_GHI, ST_VA, ST_VC, ST_WR,
    ST_D1, ST_D1W, ST_D2, ST_D2W, ST_SQ, ST_SQW,
    ST_L1, ST_L2, ST_L3, ST_D3, ST_D3W, ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    MS_NONE, MS_GRAD, MS_M_OLD, MS_M_G, MS_GSQ, MS_V_LO, MS_V_HI,
    MS_G_LO, MS_G_HI, MS_P1, MS_P2, MS_LR_LO, MS_LR_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD, ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_P1, CAP_P2, CAP_G, CAP_M, CAP_GSQ, CAP_V,
    CAP_BIGM, CAP_VH, CAP_ROOT, CAP_MAG
  } cap_sel_e;

  typedef enum logic [1:0] {
    DS_M, DS_W, DS_LR
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     clr;
    logic     mem_rd;
    logic     mem_wr;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    cap_sel_e cap_sel;
    logic     div_start;
    div_sel_e div_sel;
    logic     sqrt_start;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic sqrt_done;
    logic out_full;
  } sts_t;

endpackage

// ----- hdl/adamwu_ctrl.sv -----
module adamwu_ctrl
  import adamwu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_P1;
        end
      end
      // moment updates run through the shared multiplier, one product a cycle
      ST_P1: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.mul_sel = MS_P1;
        state_d = ST_P2;
      end
      ST_P2: begin
        cmd_o.mul_sel = MS_P2;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_GR;
      end
      ST_GR: begin
        cmd_o.mul_sel = MS_GRAD;
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.cap_sel = CAP_P1;
        state_d = ST_MO;
      end
      ST_MO: begin
        cmd_o.mul_sel = MS_M_OLD;
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.cap_sel = CAP_P2;
        state_d = ST_G;
      end
      ST_G: begin
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.cap_sel = CAP_G;
        state_d = ST_MG;
      end
      ST_MG: begin
        cmd_o.mul_sel = MS_M_G;
        state_d = ST_GS;
      end
      ST_GS: begin
        cmd_o.mul_sel = MS_GSQ;
        cmd_o.acc_op = ACC_ADD;
        state_d = ST_VLO;
      end
      ST_VLO: begin
        cmd_o.mul_sel = MS_V_LO;
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.cap_sel = CAP_M;
        state_d = ST_VHI;
      end
      ST_VHI: begin
        cmd_o.mul_sel = MS_V_HI;
        cmd_o.acc_op = ACC_LOAD;
        cmd_o.cap_sel = CAP_GSQ;
        state_d = ST_GLO;
      end
      ST_GLO: begin
        cmd_o.mul_sel = MS_G_LO;
        cmd_o.acc_op = ACC_ADD_HI;
        state_d = ST_GHI;
      end
      ST_GHI: begin
        cmd_o.mul_sel = MS_G_HI;
        cmd_o.acc_op = ACC_ADD;
        state_d = ST_VA;
      end
      ST_VA: begin
        cmd_o.acc_op = ACC_ADD_HI;
        state_d = ST_VC;
      end
      ST_VC: begin
        cmd_o.cap_sel = CAP_V;
        state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.mem_wr = 1'b1;
        state_d = ST_D1;
      end
      ST_D1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = DS_M;
        state_d = ST_D1W;
      end
      ST_D1W: begin
        if (sts_i.div_done) begin
          cmd_o.cap_sel = CAP_BIGM;
          state_d = ST_D2;
        end
      end
      ST_D2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = DS_W;
        state_d = ST_D2W;
      end
      ST_D2W: begin
        if (sts_i.div_done) begin
          cmd_o.cap_sel = CAP_VH;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = ST_SQW;
      end
      ST_SQW: begin
        if (sts_i.sqrt_done) begin
          cmd_o.cap_sel = CAP_ROOT;
          state_d = ST_L1;
        end
      end
      ST_L1: begin
        cmd_o.mul_sel = MS_LR_LO;
        state_d = ST_L2;
      end
      ST_L2: begin
        cmd_o.mul_sel = MS_LR_HI;
        cmd_o.acc_op = ACC_LOAD;
        state_d = ST_L3;
      end
      ST_L3: begin
        cmd_o.acc_op = ACC_ADD_HI;
        state_d = ST_D3;
      end
      ST_D3: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = DS_LR;
        state_d = ST_D3W;
      end
      ST_D3W: begin
        if (sts_i.div_done) begin
          cmd_o.cap_sel = CAP_MAG;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/adamwu_div.sv -----
module adamwu_div
  import adamwu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivN-1:0]    dividend_i,
  input  logic [DivDsrW-1:0] divisor_i,
  output logic [DivN-1:0]    quotient_o,
  output logic               done_o
);

  logic [DivN-1:0]    quo_q;
  logic [DivDsrW-1:0] rem_q, dsr_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDsrW:0]   rem_sh, rem_sub;
  logic               ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_q, quo_q[DivN-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivN);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivN-2:0], ge};
      rem_q <= ge ? rem_sub[DivDsrW-1:0] : rem_sh[DivDsrW-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- hdl/adamwu_dp.sv -----
module adamwu_dp
  import adamwu_pkg::*;
#(
  parameter int ROWS_MAX = RowsMaxDef,
  parameter int COLS_MAX = ColsMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [IdxW-1:0]     row_index_i,
  input  logic [IdxW-1:0]     col_index_i,
  input  logic                is_bias_i,
  input  logic [DataW-1:0]    output_grad_i,
  input  logic [DataW-1:0]    activation_i,
  input  logic                pass_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DataW-1:0]    update_value_o,
  output logic                saturated_o
);

  localparam int Depth = ROWS_MAX * COLS_MAX + ROWS_MAX;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int EntW  = MomW + VarW;
  localparam logic signed [AccW-1:0] AccI32Max = AccW'(64'sh7FFF_FFFF);
  localparam logic signed [AccW-1:0] AccI32Min = AccW'(-64'sh8000_0000);

  // configuration
  logic [LrW-1:0]   lr_q;
  logic [BetaW-1:0] b1_q, b2_q;
  logic [EpsW-1:0]  eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LrReset;
      b1_q  <= Beta1Reset;
      b2_q  <= Beta2Reset;
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LR:    lr_q  <= cfg_data_i[LrW-1:0];
        CFG_BETA1: b1_q  <= cfg_data_i[BetaW-1:0];
        CFG_BETA2: b2_q  <= cfg_data_i[BetaW-1:0];
        CFG_EPS:   eps_q <= cfg_data_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  logic                    bias_q, start_q;
  logic signed [DataW-1:0] og_q, act_q;
  logic                    oob_q;
  logic [AddrW-1:0]        idx_q;
  logic                    oob_in;
  logic [31:0]             idx_full;

  always_comb begin
    oob_in = (32'(row_index_i) >= 32'(ROWS_MAX)) ||
             (!is_bias_i && (32'(col_index_i) >= 32'(COLS_MAX)));
    if (oob_in) begin
      idx_full = '0;
    end else if (is_bias_i) begin
      idx_full = 32'(ROWS_MAX * COLS_MAX) + 32'(row_index_i);
    end else begin
      idx_full = 32'(row_index_i) * 32'(COLS_MAX) + 32'(col_index_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bias_q  <= is_bias_i;
      start_q <= pass_start_i;
      og_q    <= output_grad_i;
      act_q   <= activation_i;
      oob_q   <= oob_in;
      idx_q   <= idx_full[AddrW-1:0];
    end
  end

  // moment store, swept to zero after reset
  logic [EntW-1:0]  mem [Depth];
  logic [EntW-1:0]  rd_q;
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr && (clr_cnt_q != AddrW'(Depth - 1))) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  logic signed [MomW-1:0] m_q, g_q;
  logic [VarW-1:0]        v_q, gsq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.mem_wr && !oob_q) begin
      mem[idx_q] <= {m_q, v_q};
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[idx_q];
    end
  end

  logic signed [MomW-1:0] m_old;
  logic [VarW-1:0]        v_old;
  assign m_old = rd_q[EntW-1:VarW];
  assign v_old = rd_q[VarW-1:0];

  // correction powers
  logic [PowW-1:0] p1_q, p2_q;
  logic [PowW-1:0] d1, d2;
  assign d1 = (p1_q == OneQ31) ? OneQ31 : OneQ31 - p1_q;
  assign d2 = (p2_q == OneQ31) ? OneQ31 : OneQ31 - p2_q;

  // shared multiplier, product registered before accumulation
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_sh;
  logic [BetaW:0]          omb1, omb2;
  logic [MomW-1:0]         gabs, mabs;
  logic [62:0]             bigm_q;
  logic [SqrtInW-1:0]      vh_q;
  logic [SqrtOutW-1:0]     root_q;

  assign omb1 = 17'h1_0000 - {1'b0, b1_q};
  assign omb2 = 17'h1_0000 - {1'b0, b2_q};
  assign gabs = g_q[MomW-1] ? 32'(-g_q) : 32'(g_q);
  assign mabs = m_q[MomW-1] ? 32'(-m_q) : 32'(m_q);
  assign acc_sh = acc_q >>> 16;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MS_GRAD: begin
        mul_a = MulW'(og_q);
        mul_b = MulW'(act_q);
      end
      MS_M_OLD: begin
        mul_a = {18'b0, b1_q};
        mul_b = MulW'(m_old);
      end
      MS_M_G: begin
        mul_a = {17'b0, omb1};
        mul_b = MulW'(g_q);
      end
      MS_GSQ: begin
        mul_a = {2'b0, gabs};
        mul_b = {2'b0, gabs};
      end
      MS_V_LO: begin
        mul_a = {18'b0, b2_q};
        mul_b = {2'b0, v_old[31:0]};
      end
      MS_V_HI: begin
        mul_a = {18'b0, b2_q};
        mul_b = {18'b0, v_old[VarW-1:32]};
      end
      MS_G_LO: begin
        mul_a = {17'b0, omb2};
        mul_b = {2'b0, gsq_q[31:0]};
      end
      MS_G_HI: begin
        mul_a = {17'b0, omb2};
        mul_b = {18'b0, gsq_q[VarW-1:32]};
      end
      MS_P1: begin
        mul_a = {18'b0, b1_q};
        mul_b = {2'b0, p1_q};
      end
      MS_P2: begin
        mul_a = {18'b0, b2_q};
        mul_b = {2'b0, p2_q};
      end
      MS_LR_LO: begin
        mul_a = {10'b0, lr_q};
        mul_b = {2'b0, bigm_q[31:0]};
      end
      MS_LR_HI: begin
        mul_a = {10'b0, lr_q};
        mul_b = {3'b0, bigm_q[62:32]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      ACC_LOAD:   acc_q <= AccW'(prod_q);
      ACC_ADD:    acc_q <= acc_q + AccW'(prod_q);
      ACC_ADD_HI: acc_q <= acc_q + (AccW'(prod_q) <<< 32);
      default: ;
    endcase
  end

  // divider and square root
  logic [DivN-1:0]    div_dvd, div_quo;
  logic [DivDsrW-1:0] div_dsr;
  logic               div_done;
  logic [VarW:0]      w_sum, w;

  assign w_sum = {1'b0, v_q} + (VarW+1)'(eps_q);
  assign w     = (w_sum == '0) ? (VarW+1)'(1) : w_sum;

  always_comb begin
    case (cmd_i.div_sel)
      DS_M: begin
        div_dvd = {25'b0, mabs, 31'b0};
        div_dsr = d1;
      end
      DS_W: begin
        div_dvd = {8'b0, w, 31'b0};
        div_dsr = d2;
      end
      DS_LR: begin
        div_dvd = acc_q[DivN-1:0];
        div_dsr = root_q;
      end
      default: begin
        div_dvd = '0;
        div_dsr = DivDsrW'(1);
      end
    endcase
  end

  adamwu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // digit-by-digit square root, two radicand bits a cycle
  logic [SqrtInW-1:0]  sq_x_q;
  logic [34:0]         sq_rem_q, sq_rem_sh, sq_trial;
  logic [SqrtOutW-1:0] sq_root_q;
  logic [SqrtCntW-1:0] sq_cnt_q;
  logic                sq_busy_q, sq_done_q, sq_ge;

  assign sq_rem_sh = {sq_rem_q[32:0], sq_x_q[SqrtInW-1:SqrtInW-2]};
  assign sq_trial  = {1'b0, sq_root_q, 2'b01};
  assign sq_ge     = sq_rem_sh >= sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_done_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else begin
      sq_done_q <= sq_busy_q && (sq_cnt_q == SqrtCntW'(1));
      if (cmd_i.sqrt_start) begin
        sq_busy_q <= 1'b1;
        sq_cnt_q  <= SqrtCntW'(SqrtOutW);
      end else if (sq_busy_q) begin
        sq_cnt_q <= sq_cnt_q - SqrtCntW'(1);
        if (sq_cnt_q == SqrtCntW'(1)) sq_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sq_x_q    <= vh_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (sq_busy_q) begin
      sq_x_q    <= {sq_x_q[SqrtInW-3:0], 2'b00};
      sq_rem_q  <= sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
      sq_root_q <= {sq_root_q[SqrtOutW-2:0], sq_ge};
    end
  end

  // result capture
  logic [79:0]      mag;
  logic             neg;
  logic [DataW-1:0] res_q;
  logic             res_sat_q;

  assign mag = div_quo[DivN-1:8];
  assign neg = m_q > 0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= OneQ31;
      p2_q <= OneQ31;
    end else begin
      if (cmd_i.cap_sel == CAP_P1 && start_q) p1_q <= acc_q[47:16];
      if (cmd_i.cap_sel == CAP_P2 && start_q) p2_q <= acc_q[47:16];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.cap_sel)
      CAP_G: begin
        if (bias_q) g_q <= og_q;
        else if (acc_sh > AccI32Max) g_q <= AccI32Max[MomW-1:0];
        else if (acc_sh < AccI32Min) g_q <= AccI32Min[MomW-1:0];
        else g_q <= acc_sh[MomW-1:0];
      end
      CAP_M:   m_q <= acc_sh[MomW-1:0];
      CAP_GSQ: gsq_q <= (|acc_q[AccW-1:VarW]) ? '1 : acc_q[VarW-1:0];
      CAP_V:   v_q <= acc_q[63:16];
      CAP_BIGM: bigm_q <= div_quo[62:0];
      CAP_VH:  vh_q <= (|div_quo[DivN-1:SqrtInW]) ? '1 : div_quo[SqrtInW-1:0];
      CAP_ROOT: root_q <= sq_root_q;
      CAP_MAG: begin
        if (oob_q) begin
          res_q     <= '0;
          res_sat_q <= 1'b0;
        end else if (neg) begin
          if (mag > 80'h8000_0000) begin
            res_q     <= 32'h8000_0000;
            res_sat_q <= 1'b1;
          end else begin
            res_q     <= 32'(-mag[31:0]);
            res_sat_q <= 1'b0;
          end
        end else begin
          if (mag > 80'h7FFF_FFFF) begin
            res_q     <= 32'h7FFF_FFFF;
            res_sat_q <= 1'b1;
          end else begin
            res_q     <= mag[31:0];
            res_sat_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  logic             out_valid_q;
  logic [DataW-1:0] out_val_q;
  logic             out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_val_q <= res_q;
      out_sat_q <= res_sat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign update_value_o = out_val_q;
  assign saturated_o    = out_sat_q;

  assign sts_o.clr_done  = (clr_cnt_q == AddrW'(Depth - 1));
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sq_done_q;
  assign sts_o.out_full  = out_valid_q;

endmodule

// ----- hdl/adam_weight_update.sv -----
// one item at a time; each runs through three 88-bit bit-serial divisions and a
// 32-bit square root around the shared 34x34 multiplier
// a finished result waits in the output register while the next item is taken
// reset: asynchronous, resets control and config registers, then a clearing pass
// over all ROWS_MAX*COLS_MAX+ROWS_MAX entries zeroes the moment store with
// in_ready_o low
module adam_weight_update
  import adamwu_pkg::*;
#(
  parameter int ROWS_MAX = RowsMaxDef,
  parameter int COLS_MAX = ColsMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [IdxW-1:0]     row_index_i,
  input  logic [IdxW-1:0]     col_index_i,
  input  logic                is_bias_i,
  input  logic [DataW-1:0]    output_grad_i,
  input  logic [DataW-1:0]    activation_i,
  input  logic                pass_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DataW-1:0]    update_value_o,
  output logic                saturated_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  adamwu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adamwu_dp #(
    .ROWS_MAX (ROWS_MAX),
    .COLS_MAX (COLS_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .is_bias_i      (is_bias_i),
    .output_grad_i  (output_grad_i),
    .activation_i   (activation_i),
    .pass_start_i   (pass_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .update_value_o (update_value_o),
    .saturated_o    (saturated_o)
  );

endmodule

// ----- hdl/adamwu_check.sv -----
module adamwu_check
  import adamwu_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [DataW-1:0] update_value_o,
  input logic             saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(update_value_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // clamped results sit exactly at one of the two rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (update_value_o == 32'h8000_0000) || (update_value_o == 32'h7FFF_FFFF))
    else $error("saturated flag without clamped value");

  // one item in flight: input closes after each transaction
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

endmodule

bind adam_weight_update adamwu_check u_adamwu_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .update_value_o (update_value_o),
  .saturated_o    (saturated_o)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import adamwu_pkg::*;

  localparam int StoreDepth = RowsMaxDef * ColsMaxDef + RowsMaxDef;
  localparam int IdleLimit  = 40000;

  typedef struct {
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic             bias;
    logic [DataW-1:0] grad;
    logic [DataW-1:0] act;
    logic             pass_start;
  } elem_t;

  typedef struct {
    logic [DataW-1:0] delta;
    logic             sat;
  } delta_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_idx_e            cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [IdxW-1:0]     row_index;
  logic [IdxW-1:0]     col_index;
  logic                is_bias;
  logic [DataW-1:0]    output_grad;
  logic [DataW-1:0]    activation;
  logic                pass_start;
  logic                out_valid;
  logic                out_ready;
  logic [DataW-1:0]    update_value;
  logic                saturated;

  // predictor state
  logic [LrW-1:0]   lr_q;
  logic [BetaW-1:0] b1_q;
  logic [BetaW-1:0] b2_q;
  logic [EpsW-1:0]  eps_q;
  int               first_mom[StoreDepth];
  logic [63:0]      second_mom[StoreDepth];
  logic [PowW-1:0]  pow1_q;
  logic [PowW-1:0]  pow2_q;

  delta_t pending_deltas[$];

  int  n_items, n_results, n_sat, n_mismatch;
  int  idle_cycles;
  int  hold_cycles;
  int  stall_burst;
  bit  idle_en;

  adam_weight_update uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .row_index_i   (row_index),
    .col_index_i   (col_index),
    .is_bias_i     (is_bias),
    .output_grad_i (output_grad),
    .activation_i  (activation),
    .pass_start_i  (pass_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .update_value_o(update_value),
    .saturated_o   (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > x) probe = probe >> 2;
    while (probe != 0) begin
      if (x >= root + probe) begin
        x    = x - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // adam step on one element, updates moments and powers
  function automatic delta_t adam_step(input elem_t e);
    int          idx;
    longint      g, m, prod;
    logic [63:0] gsq, v, w, d1, d2, mabs, bigm, hi, vh, root, q, r, mag;
    bit          neg;
    delta_t      res;
    if (e.pass_start) begin
      pow1_q = 32'((64'(pow1_q) * 64'(b1_q)) >> 16);
      pow2_q = 32'((64'(pow2_q) * 64'(b2_q)) >> 16);
    end
    idx = e.bias ? RowsMaxDef * ColsMaxDef + int'(e.row)
                 : int'(e.row) * ColsMaxDef + int'(e.col);
    if (e.bias) begin
      g = longint'($signed(e.grad));
    end else begin
      prod = longint'($signed(e.grad)) * longint'($signed(e.act));
      g = prod >>> 16;
      if (g > 64'sd2147483647) g = 64'sd2147483647;
      if (g < -64'sd2147483648) g = -64'sd2147483648;
    end
    m = (longint'(b1_q) * longint'(first_mom[idx]) + (65536 - longint'(b1_q)) * g) >>> 16;
    first_mom[idx] = int'(m);

    gsq = (g < 0) ? 64'(-g) : 64'(g);
    gsq = gsq * gsq;
    if (gsq > (64'd1 << 48) - 1) gsq = (64'd1 << 48) - 1;
    v = (64'(b2_q) * second_mom[idx] + (64'd65536 - 64'(b2_q)) * gsq) >> 16;
    second_mom[idx] = v;

    d1 = 64'(OneQ31) - 64'(pow1_q);
    if (d1 == 0) d1 = 64'(OneQ31);
    d2 = 64'(OneQ31) - 64'(pow2_q);
    if (d2 == 0) d2 = 64'(OneQ31);

    neg  = (m > 0);
    mabs = (m < 0) ? 64'(-m) : 64'(m);
    bigm = (mabs << 31) / d1;

    w = v + 64'(eps_q);
    if (w == 0) w = 1;
    hi = w / d2;
    if (hi >= (64'd1 << 33)) vh = '1;
    else vh = (hi << 31) + (((w % d2) << 31) / d2);
    root = isqrt64(vh);

    q = bigm / root;
    r = bigm % root;
    if (lr_q != 0 && q >= (64'd1 << 40)) mag = 64'd1 << 32;
    else mag = (64'(lr_q) * q + (64'(lr_q) * r) / root) >> 8;

    res.sat = 1'b0;
    if (neg) begin
      if (mag > 64'(OneQ31)) begin
        mag = 64'(OneQ31);
        res.sat = 1'b1;
      end
      res.delta = 32'(-mag);
    end else begin
      if (mag > 64'(OneQ31) - 1) begin
        mag = 64'(OneQ31) - 1;
        res.sat = 1'b1;
      end
      res.delta = 32'(mag);
    end
    return res;
  endfunction

  task automatic send_elem(input elem_t e, input bit may_gap);
    int gap;
    in_valid    <= 1'b1;
    row_index   <= e.row;
    col_index   <= e.col;
    is_bias     <= e.bias;
    output_grad <= e.grad;
    activation  <= e.act;
    pass_start  <= e.pass_start;
    do @(posedge clk); while (!in_ready);
    pending_deltas.push_back(adam_step(e));
    n_items++;
    if (may_gap && idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_deltas.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LR:    lr_q  = val[LrW-1:0];
      CFG_BETA1: b1_q  = val[BetaW-1:0];
      CFG_BETA2: b2_q  = val[BetaW-1:0];
      CFG_EPS:   eps_q = val[EpsW-1:0];
      default:   ;
    endcase
    @(posedge clk);
  endtask

  function automatic elem_t make_elem(input logic [IdxW-1:0] row, input logic [IdxW-1:0] col,
                                      input logic bias, input logic [31:0] grad,
                                      input logic [31:0] act, input logic ps);
    elem_t e;
    e.row = row; e.col = col; e.bias = bias;
    e.grad = grad; e.act = act; e.pass_start = ps;
    return e;
  endfunction

  // gradient-like value with a random magnitude scale
  function automatic logic [31:0] rand_q16();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 5))
      0:       return raw;
      1:       return 32'($signed(raw) >>> 20);
      2:       return 32'($signed(raw) >>> 14);
      3:       return 32'($signed(raw) >>> 8);
      4:       return {32{raw[0]}} ^ 32'($urandom_range(0, 3));
      default: return 32'($signed(raw) >>> 4);
    endcase
  endfunction

  function automatic logic [BetaW-1:0] rand_beta();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(52000, 65535));
    endcase
  endfunction

  // directed elements; before any pass start the correction divisor falls back to one
  task automatic test_directed();
    send_elem(make_elem(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0), 1);
    send_elem(make_elem(63, 63, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0), 1);
    send_elem(make_elem(63, 62, 0, 32'h8000_0000, 32'h7fff_ffff, 0), 1);
    send_elem(make_elem(62, 63, 0, 32'h8000_0000, 32'h8000_0000, 0), 1);
    send_elem(make_elem(1, 2, 0, 32'h0000_0000, 32'hffff_ffff, 0), 1);
    send_elem(make_elem(0, 63, 1, 32'h7fff_ffff, 32'h0, 1), 1);
    send_elem(make_elem(63, 0, 1, 32'h8000_0000, 32'hffff_ffff, 0), 1);
    send_elem(make_elem(5, 9, 1, 32'hffff_ffff, 32'h1234_5678, 0), 1);
    send_elem(make_elem(5, 9, 0, 32'h0000_0001, 32'h0000_0001, 1), 1);
    send_elem(make_elem(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0), 1);
    send_elem(make_elem(0, 0, 0, 32'hffff_0000, 32'h0002_0000, 1), 1);
    send_elem(make_elem(42, 21, 0, 32'h5555_5555, 32'haaaa_aaaa, 0), 1);
    send_elem(make_elem(21, 42, 1, 32'haaaa_aaaa, 32'h5555_5555, 0), 1);
    wait_drained();
    // zero first and second moments with no epsilon
    write_reg(CFG_EPS, 0);
    send_elem(make_elem(10, 11, 0, 32'h0, 32'h7fff_ffff, 0), 1);
    send_elem(make_elem(12, 0, 1, 32'h0, 32'h0, 0), 1);
    wait_drained();
    // extreme step size and decays
    write_reg(CFG_LR, '1);
    write_reg(CFG_BETA1, 0);
    write_reg(CFG_BETA2, '1);
    write_reg(CFG_EPS, 16'hffff);
    send_elem(make_elem(3, 3, 0, 32'h7fff_ffff, 32'h0000_0100, 1), 1);
    send_elem(make_elem(3, 3, 0, 32'h8000_0000, 32'h0000_0100, 0), 1);
    send_elem(make_elem(4, 0, 1, 32'h0000_0001, 32'h0, 1), 1);
    wait_drained();
    write_reg(CFG_LR, 0);
    write_reg(CFG_BETA1, '1);
    write_reg(CFG_BETA2, 0);
    send_elem(make_elem(3, 3, 0, 32'h0100_0000, 32'h0100_0000, 1), 1);
    send_elem(make_elem(4, 0, 1, 32'hff00_0000, 32'h0, 0), 1);
    wait_drained();
  endtask

  // training-like passes over a small parameter set, with some stray elements
  task automatic test_training_passes(input int n_elems);
    int sent;
    int rows, cols;
    logic [IdxW-1:0] base_r, base_c;
    elem_t e;
    sent = 0;
    while (sent < n_elems) begin
      rows   = $urandom_range(1, 4);
      cols   = $urandom_range(1, 4);
      base_r = IdxW'($urandom_range(0, 64 - rows));
      base_c = IdxW'($urandom_range(0, 64 - cols));
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c <= cols; c++) begin
          e.row        = IdxW'(int'(base_r) + r);
          e.col        = (c == cols) ? IdxW'($urandom) : IdxW'(int'(base_c) + c);
          e.bias       = (c == cols);
          e.grad       = rand_q16();
          e.act        = rand_q16();
          e.pass_start = (r == 0 && c == 0);
          if ($urandom_range(0, 9) == 0) begin
            e.row        = IdxW'($urandom);
            e.col        = IdxW'($urandom);
            e.bias       = 1'($urandom);
            e.pass_start = 1'($urandom);
          end
          send_elem(e, 1);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_configs();
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_LR, '1);
        1:       write_reg(CFG_LR, 24'($urandom_range(1, 300)));
        default: write_reg(CFG_LR, 24'($urandom));
      endcase
      write_reg(CFG_BETA1, rand_beta());
      write_reg(CFG_BETA2, rand_beta());
      write_reg(CFG_EPS, ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom));
      test_training_passes(300);
    end
    wait_drained();
    write_reg(CFG_LR, LrReset);
    write_reg(CFG_BETA1, Beta1Reset);
    write_reg(CFG_BETA2, Beta2Reset);
    write_reg(CFG_EPS, EpsReset);
  endtask

  // receiver stalls long enough that the block fills and stops taking input
  task automatic test_output_backpressure();
    elem_t e;
    hold_cycles = 2500;
    for (int i = 0; i < 6; i++) begin
      e.row = IdxW'($urandom); e.col = IdxW'($urandom); e.bias = 1'($urandom);
      e.grad = rand_q16(); e.act = rand_q16(); e.pass_start = (i == 0);
      send_elem(e, 0);
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else if (stall_burst > 0) begin
      out_ready <= 1'b0;
      stall_burst--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_burst = $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    delta_t exp_d;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (saturated) n_sat++;
      if (pending_deltas.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected update %h sat %b", $realtime, update_value, saturated);
      end else begin
        exp_d = pending_deltas.pop_front();
        if (update_value !== exp_d.delta || saturated !== exp_d.sat) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: update exp %h sat %b, got %h sat %b", $realtime,
                     exp_d.delta, exp_d.sat, update_value, saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_LR; cfg_data = '0;
    in_valid = 1'b0; row_index = '0; col_index = '0; is_bias = 1'b0;
    output_grad = '0; activation = '0; pass_start = 1'b0;
    out_ready = 1'b0;
    n_items = 0; n_results = 0; n_sat = 0; n_mismatch = 0;
    idle_cycles = 0; hold_cycles = 0; stall_burst = 0; idle_en = 1'b1;
    lr_q = LrReset; b1_q = Beta1Reset; b2_q = Beta2Reset; eps_q = EpsReset;
    pow1_q = OneQ31; pow2_q = OneQ31;
    for (int i = 0; i < StoreDepth; i++) begin
      first_mom[i]  = 0;
      second_mom[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_configs();
    test_output_backpressure();
    idle_en = 1'b0;
    test_training_passes(300);
    wait_drained();
    repeat (400) @(posedge clk);

    $display("covered %0d elements over several step-size and decay settings,", n_items);
    $display("%0d updates checked, %0d saturated, %0d mismatches", n_results, n_sat, n_mismatch);
    if (n_mismatch == 0 && pending_deltas.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/adamwu_pkg.sv
hdl/adamwu_ctrl.sv
hdl/adamwu_div.sv
hdl/adamwu_dp.sv
hdl/adam_weight_update.sv
hdl/adamwu_check.sv
tb/sv/tb.sv
